@@ design/assert_macros.svh @@
// assertion macros used by the list engine
// each check is sampled on the rising clock edge and is off while reset is held
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OAL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("oal assertion failed");
`define OAL_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("oal condition must not occur");
`else
`define OAL_ASSERT(label, prop)
`define OAL_NEVER(label, cond)
`endif
`endif

@@ design/oal_pkg.sv @@
`default_nettype none

package oal_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int ACT_W   = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int FOUND_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT       = 2'd0,
        ACT_DELETE_AT    = 2'd1,
        ACT_DELETE_VALUE = 2'd2,
        ACT_READ         = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_BAD_INDEX = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    // what the row of cells does in a given cycle
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        action_t                  action;
        logic signed [VAL_W-1:0]  item_value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [FOUND_W-1:0]       found_position;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [VAL_W-1:0]  largest_value;
        logic signed [VAL_W-1:0]  smallest_value;
        logic                     list_empty;
    } rsp_t;

    // flags travelling along the compare chain
    typedef struct packed {
        logic hit;
        logic any;
    } chain_flags_t;

endpackage

`default_nettype wire

@@ design/oal_cell.sv @@
`default_nettype none

module oal_cell #(
    parameter int CAPACITY    = oal_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = oal_pkg::DEF_VALUE_WIDTH,
    parameter int IDX         = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire oal_pkg::cell_cmd_t               cmd,
    input  wire logic [$clog2(CAPACITY)-1:0]      pos_idx,
    input  wire logic [$clog2(CAPACITY+1)-1:0]    cnt,
    input  wire logic [VALUE_WIDTH-1:0]           value,
    input  wire logic [VALUE_WIDTH-1:0]           left_entry,
    input  wire logic [VALUE_WIDTH-1:0]           right_entry,
    output logic [VALUE_WIDTH-1:0]                entry,
    input  wire oal_pkg::chain_flags_t            flags_in,
    input  wire logic [$clog2(CAPACITY)-1:0]      idx_in,
    input  wire logic [VALUE_WIDTH-1:0]           rd_in,
    input  wire logic [VALUE_WIDTH-1:0]           hi_in,
    input  wire logic [VALUE_WIDTH-1:0]           lo_in,
    output oal_pkg::chain_flags_t                 flags_out,
    output logic [$clog2(CAPACITY)-1:0]           idx_out,
    output logic [VALUE_WIDTH-1:0]                rd_out,
    output logic [VALUE_WIDTH-1:0]                hi_out,
    output logic [VALUE_WIDTH-1:0]                lo_out
);
    import oal_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VALUE_WIDTH-1:0] entry_reg, entry_next;
    chain_flags_t           flags_reg;
    logic [IW-1:0]          idx_reg;
    logic [VALUE_WIDTH-1:0] rd_reg, hi_reg, lo_reg;
    logic                   live, match;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd)
            CMD_INSERT:
            begin
                if (pos_idx == IDX_I)
                    entry_next = value;
                else if (pos_idx < IDX_I)
                    entry_next = left_entry;
            end
            CMD_REMOVE:
            begin
                if (pos_idx <= IDX_I)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        idx_reg   <= idx_in;
        rd_reg    <= rd_in;
        hi_reg    <= hi_in;
        lo_reg    <= lo_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_in;
    end

    assign entry = entry_reg;
    assign live  = cnt > IDX_C;
    assign match = live && (entry_reg == value);

    // first match wins, later cells only pass it on
    always_comb
    begin
        flags_out.hit = flags_reg.hit | match;
        flags_out.any = flags_reg.any | live;
        idx_out       = flags_reg.hit ? idx_reg : IDX_I;
        rd_out        = (cmd == CMD_READ && pos_idx == IDX_I) ? entry_reg : rd_reg;
        hi_out        = hi_reg;
        lo_out        = lo_reg;
        if (live)
        begin
            if (!flags_reg.any)
            begin
                hi_out = entry_reg;
                lo_out = entry_reg;
            end
            else
            begin
                if ($signed(entry_reg) > $signed(hi_reg))
                    hi_out = entry_reg;
                if ($signed(entry_reg) < $signed(lo_reg))
                    lo_out = entry_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/ordered_array_list_engine.sv @@
// Ordered list of up to CAPACITY signed values held in a row of cells, one entry per
// cell. Insert and delete shift the entries from the insert or delete position on by one
// place in the update state. The largest and smallest entry, the entry read and the first
// match of a delete by value are found by a compare chain that advances one cell per cycle,
// so the response is loaded at the end of the scan that follows the update (insert,
// delete at index, read); a delete by value runs the chain once to search before the
// update and once more after the shift. One request is in progress at a time; req_ready
// returns the cycle after the response is loaded, even while that response still waits
// for rsp_ready. A response still waiting for rsp_ready holds the next one back in its
// last chain cycle until the response register is free.
`default_nettype none
`include "assert_macros.svh"

module ordered_array_list_engine #(
    parameter int CAPACITY    = oal_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = oal_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire oal_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output oal_pkg::rsp_t      rsp
);
    import oal_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_SCAN   = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    req_t           req_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  wait_reg, wait_next;
    status_t        status_reg, status_next;
    logic           found_hit_reg, found_hit_next;
    logic [IW-1:0]  found_idx_reg, found_idx_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg;
    logic           rsp_load;

    logic [MW-1:0]          pos_m, cnt_m, cap_m;
    logic [IW-1:0]          pos_idx, cell_pos;
    logic [VALUE_WIDTH-1:0] value_w;
    cell_cmd_t              cmd;

    logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
    logic [VALUE_WIDTH-1:0] left_w  [CAPACITY];
    logic [VALUE_WIDTH-1:0] right_w [CAPACITY];
    chain_flags_t           chain_flags [CAPACITY+1];
    logic [IW-1:0]          chain_idx   [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] chain_rd    [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] chain_hi    [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] chain_lo    [CAPACITY+1];

    assign pos_m   = MW'(req_reg.position);
    assign cnt_m   = MW'(count_reg);
    assign cap_m   = MW'(CAPACITY);
    assign pos_idx = IW'(req_reg.position);
    assign value_w = VALUE_WIDTH'(req_reg.item_value);

    always_comb
    begin
        status_next = STAT_OK;
        case (req_reg.action)
            ACT_INSERT:
            begin
                if (cnt_m == cap_m)
                    status_next = STAT_FULL;
                else if (pos_m > cnt_m)
                    status_next = STAT_BAD_INDEX;
            end
            ACT_DELETE_AT:
            begin
                if (pos_m >= cnt_m)
                    status_next = STAT_BAD_INDEX;
            end
            ACT_DELETE_VALUE:
            begin
                if (!found_hit_reg)
                    status_next = STAT_NOT_FOUND;
            end
            ACT_READ:
            begin
                if (count_reg == '0)
                    status_next = STAT_EMPTY;
                else if (pos_m >= cnt_m)
                    status_next = STAT_BAD_INDEX;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // broadcast to the row
    always_comb
    begin
        cmd      = CMD_HOLD;
        cell_pos = pos_idx;
        if (state_reg == ST_UPDATE && status_next == STAT_OK)
        begin
            case (req_reg.action)
                ACT_INSERT:       cmd = CMD_INSERT;
                ACT_DELETE_AT:    cmd = CMD_REMOVE;
                ACT_DELETE_VALUE:
                begin
                    cmd      = CMD_REMOVE;
                    cell_pos = found_idx_reg;
                end
                default:          cmd = CMD_HOLD;
            endcase
        end
        else if (state_reg == ST_SCAN && req_reg.action == ACT_READ && status_reg == STAT_OK)
        begin
            cmd = CMD_READ;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        found_hit_next = found_hit_reg;
        found_idx_next = found_idx_reg;
        rsp_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                wait_next = '0;
                if (req_valid)
                begin
                    if (req.action == ACT_DELETE_VALUE)
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_UPDATE;
                end
            end
            ST_SEARCH:
            begin
                if (wait_reg == LAST_STEP)
                begin
                    found_hit_next = chain_flags[CAPACITY].hit;
                    found_idx_next = chain_idx[CAPACITY];
                    wait_next      = '0;
                    state_next     = ST_UPDATE;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                wait_next  = '0;
                state_next = ST_SCAN;
                if (status_next == STAT_OK)
                begin
                    if (req_reg.action == ACT_INSERT)
                        count_next = count_reg + 1'b1;
                    else if (req_reg.action == ACT_DELETE_AT
                             || req_reg.action == ACT_DELETE_VALUE)
                        count_next = count_reg - 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (wait_reg == LAST_STEP)
                begin
                    // hold here until the response register is free
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_load   = 1'b1;
                        wait_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                wait_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_hit_reg <= found_hit_next;
        found_idx_reg <= found_idx_next;
        if (req_valid && req_ready)
            req_reg <= req;
        if (state_reg == ST_UPDATE)
            status_reg <= status_next;
        if (rsp_load)
        begin
            rsp_reg.status         <= status_reg;
            rsp_reg.read_value     <= VAL_W'(chain_rd[CAPACITY]);
            rsp_reg.found_position <= (req_reg.action == ACT_DELETE_VALUE
                                       && status_reg == STAT_OK)
                                      ? FOUND_W'(found_idx_reg) : '0;
            rsp_reg.entry_count    <= COUNT_W'(count_reg);
            rsp_reg.largest_value  <= VAL_W'(chain_hi[CAPACITY]);
            rsp_reg.smallest_value <= VAL_W'(chain_lo[CAPACITY]);
            rsp_reg.list_empty     <= (count_reg == '0);
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // head of the compare chain
    assign chain_flags[0] = '0;
    assign chain_idx[0]   = '0;
    assign chain_rd[0]    = '0;
    assign chain_hi[0]    = '0;
    assign chain_lo[0]    = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_w[g] = '0;
        end
        else
        begin : g_inner_left
            assign left_w[g] = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w[g] = '0;
        end
        else
        begin : g_inner_right
            assign right_w[g] = entry_w[g+1];
        end

        oal_cell #(
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .pos_idx     (cell_pos),
            .cnt         (count_reg),
            .value       (value_w),
            .left_entry  (left_w[g]),
            .right_entry (right_w[g]),
            .entry       (entry_w[g]),
            .flags_in    (chain_flags[g]),
            .idx_in      (chain_idx[g]),
            .rd_in       (chain_rd[g]),
            .hi_in       (chain_hi[g]),
            .lo_in       (chain_lo[g]),
            .flags_out   (chain_flags[g+1]),
            .idx_out     (chain_idx[g+1]),
            .rd_out      (chain_rd[g+1]),
            .hi_out      (chain_hi[g+1]),
            .lo_out      (chain_lo[g+1])
        );
    end

    `OAL_ASSERT(a_count_range, count_reg <= CW'(CAPACITY))
    `OAL_ASSERT(a_count_only_on_update, state_reg != ST_UPDATE |=> $stable(count_reg))
    `OAL_ASSERT(a_rsp_after_scan, $rose(rsp_valid_reg) |-> $past(state_reg == ST_SCAN))
    `OAL_NEVER(a_idle_step_clear, req_ready && wait_reg != '0)

endmodule

`default_nettype wire

@@ verif/ordered_array_list_engine_test.sv @@
`timescale 1ns / 1ps

module ordered_array_list_engine_test;

    import oal_pkg::*;

    localparam int LIST_DEPTH   = DEF_CAPACITY;
    localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_LIMIT  = 40;
    localparam logic [VAL_W-1:0] EDGE_VALUES [4] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // testbench copy of the list
    logic signed [VAL_W-1:0] list_entries [LIST_DEPTH];
    int                      list_count   = 0;
    bit                      growing      = 1'b1;

    rsp_t expected_rsp [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;

    ordered_array_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ordered_array_list_engine_test: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string line);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, line);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic void remove_entry(input int at);
        for (int idx = at; idx + 1 < list_count; idx++)
            list_entries[idx] = list_entries[idx + 1];
        list_count--;
    endfunction

    // updates the list copy and returns the response the request should give
    function automatic rsp_t apply_request(input req_t r);
        rsp_t                    o;
        int                      hit;
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
        o        = '0;
        o.status = STAT_OK;
        hit      = -1;
        case (r.action)
            ACT_INSERT:
            begin
                if (list_count >= LIST_DEPTH)
                    o.status = STAT_FULL;
                else if (r.position > list_count)
                    o.status = STAT_BAD_INDEX;
                else
                begin
                    for (int idx = list_count; idx > r.position; idx--)
                        list_entries[idx] = list_entries[idx - 1];
                    list_entries[r.position] = r.item_value;
                    list_count++;
                end
            end
            ACT_DELETE_AT:
            begin
                if (r.position >= list_count)
                    o.status = STAT_BAD_INDEX;
                else
                    remove_entry(r.position);
            end
            ACT_DELETE_VALUE:
            begin
                for (int idx = 0; idx < list_count; idx++)
                    if (hit < 0 && list_entries[idx] == r.item_value)
                        hit = idx;
                if (hit < 0)
                    o.status = STAT_NOT_FOUND;
                else
                begin
                    remove_entry(hit);
                    o.found_position = hit[FOUND_W-1:0];
                end
            end
            default:
            begin
                if (list_count == 0)
                    o.status = STAT_EMPTY;
                else if (r.position >= list_count)
                    o.status = STAT_BAD_INDEX;
                else
                    o.read_value = list_entries[r.position];
            end
        endcase
        if (list_count > 0)
        begin
            hi = list_entries[0];
            lo = list_entries[0];
            for (int idx = 1; idx < list_count; idx++)
            begin
                if (list_entries[idx] > hi)
                    hi = list_entries[idx];
                if (list_entries[idx] < lo)
                    lo = list_entries[idx];
            end
            o.largest_value  = hi;
            o.smallest_value = lo;
        end
        o.entry_count = list_count[COUNT_W-1:0];
        o.list_empty  = (list_count == 0);
        return o;
    endfunction

    function automatic req_t make_req(input action_t act, input logic [VAL_W-1:0] value,
                                      input int pos);
        req_t r;
        r.action     = act;
        r.item_value = value;
        r.position   = pos[POS_W-1:0];
        return r;
    endfunction

    // mostly valid traffic that walks the count up to full and back down to empty
    function automatic req_t make_random_request();
        req_t r;
        int   pick;
        r = '0;
        if (list_count >= LIST_DEPTH && $urandom_range(1) == 1)
            growing = 1'b0;
        else if (list_count == 0 && $urandom_range(1) == 1)
            growing = 1'b1;
        else if ($urandom_range(49) == 0)
            growing = !growing;

        pick = $urandom_range(9);
        if (pick == 0)
            r.item_value = EDGE_VALUES[$urandom_range(3)];
        else if (pick < 5)
            r.item_value = 32'($urandom_range(6)) - 32'd3;
        else
            r.item_value = $urandom();
        r.position = POS_W'($urandom_range(LIST_DEPTH));

        // noise
        if ($urandom_range(99) < 8)
        begin
            r.action = action_t'($urandom_range(3));
            return r;
        end

        pick = $urandom_range(99);
        if (growing)
            r.action = (pick < 60) ? ACT_INSERT : (pick < 75) ? ACT_DELETE_AT :
                       (pick < 85) ? ACT_DELETE_VALUE : ACT_READ;
        else
            r.action = (pick < 15) ? ACT_INSERT : (pick < 50) ? ACT_DELETE_AT :
                       (pick < 75) ? ACT_DELETE_VALUE : ACT_READ;

        if ($urandom_range(9) != 0)
        begin
            if (r.action == ACT_INSERT)
                r.position = POS_W'($urandom_range(list_count));
            else if (list_count > 0)
                r.position = POS_W'($urandom_range(list_count - 1));
        end
        if (r.action == ACT_DELETE_VALUE && list_count > 0 && $urandom_range(9) < 7)
            r.item_value = list_entries[$urandom_range(list_count - 1)];
        return r;
    endfunction

    task automatic send_request(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(apply_request(item));
    endtask

    always @(posedge clk)
    begin : check_response
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("response transaction with none outstanding");
            else
            begin
                want = expected_rsp.pop_front();
                check_field("status", 32'(rsp.status), 32'(want.status));
                check_field("read_value", rsp.read_value, want.read_value);
                check_field("found_position", 32'(rsp.found_position),
                            32'(want.found_position));
                check_field("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
                check_field("largest_value", rsp.largest_value, want.largest_value);
                check_field("smallest_value", rsp.smallest_value, want.smallest_value);
                check_field("list_empty", 32'(rsp.list_empty), 32'(want.list_empty));
            end
        end
    end

    task automatic test_empty_list();
        send_request(make_req(ACT_READ, 32'd0, 0));
        send_request(make_req(ACT_DELETE_AT, 32'd0, 0));
        send_request(make_req(ACT_DELETE_VALUE, 32'd0, 0));
        send_request(make_req(ACT_INSERT, 32'd9, 1));
    endtask

    task automatic test_insert_positions();
        send_request(make_req(ACT_INSERT, 32'h7fff_ffff, 0));
        send_request(make_req(ACT_INSERT, 32'h8000_0000, 1));
        send_request(make_req(ACT_INSERT, 32'h0000_0000, 1));
        send_request(make_req(ACT_INSERT, 32'hffff_ffff, 0));
        send_request(make_req(ACT_INSERT, 32'd5, 5));
    endtask

    task automatic test_read_and_delete();
        send_request(make_req(ACT_READ, 32'd0, 3));
        send_request(make_req(ACT_READ, 32'd0, 4));
        send_request(make_req(ACT_DELETE_VALUE, 32'h8000_0000, 0));
        send_request(make_req(ACT_DELETE_VALUE, 32'd12345, 0));
        send_request(make_req(ACT_DELETE_AT, 32'd0, 3));
        send_request(make_req(ACT_DELETE_AT, 32'd0, 0));
    endtask

    // duplicates on the way up so the delete by value has to take the first match
    task automatic test_full_list();
        while (list_count < LIST_DEPTH)
            send_request(make_req(ACT_INSERT, 32'(list_count % 3), list_count / 2));
        send_request(make_req(ACT_INSERT, 32'd77, 0));
        send_request(make_req(ACT_INSERT, 32'd77, LIST_DEPTH));
        send_request(make_req(ACT_READ, 32'd0, LIST_DEPTH - 1));
        send_request(make_req(ACT_READ, 32'd0, LIST_DEPTH));
        send_request(make_req(ACT_DELETE_VALUE, 32'd1, 0));
        send_request(make_req(ACT_DELETE_AT, 32'd0, LIST_DEPTH - 1));
        send_request(make_req(ACT_DELETE_AT, 32'd0, LIST_DEPTH - 2));
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items)
            send_request(make_random_request());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 54;
        test_empty_list();
        test_insert_positions();
        test_read_and_delete();
        test_full_list();
        test_random_traffic(420);

        send_idle_pct = 54;
        recv_idle_pct = 32;
        test_random_traffic(420);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(410);

        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        // stray transactions after the last one are caught by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ordered_array_list_engine_test: done, clean");
        else
            $display("ordered_array_list_engine_test: done, errors");
        $finish;
    end

endmodule
